// ----- rtl/antialiased_line_stepper_unit_macros.svh -----
// assertion macros for the antialiased line stepper
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef ANTIALIASED_LINE_STEPPER_UNIT_MACROS_SVH
`define ANTIALIASED_LINE_STEPPER_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ALSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ALSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/alsu_pkg.sv -----
// shared types, widths and codes for the antialiased line stepper
// no dependencies; used by every module of the block
package alsu_pkg;

  // field and fixed point widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int SHADE_BITS = 4;
  localparam int CFG_BITS   = 11;
  localparam int PIX_BITS   = 10;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int MINOR_BITS = ACC_BITS - FRAC_BITS;
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int CMP_BITS   = COORD_BITS + 2;
  localparam int DIV_STEPS  = QUO_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // outcode bits, one per screen margin
  localparam int OC_BITS = 16;
  localparam logic [OC_BITS-1:0] OC_TOP    = 16'h0001;
  localparam logic [OC_BITS-1:0] OC_BOTTOM = 16'h0010;
  localparam logic [OC_BITS-1:0] OC_LEFT   = 16'h0100;
  localparam logic [OC_BITS-1:0] OC_RIGHT  = 16'h1000;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 1'b1;
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd256;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd240;

  // input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CLASS,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    CMD_STEP,
    CMD_REJECT,
    CMD_LINE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                     kind;
    logic                          major_is_x;
    logic signed [COORD_BITS-1:0]  major_pos;
    logic signed [COORD_BITS-1:0]  major_end;
    logic signed [ACC_BITS-1:0]    minor_accum;
    logic signed [SLOPE_BITS-1:0]  slope;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/antialiased_line_stepper_unit.sv -----
// Antialiased line stepper: an accepted step is queued and its pixel pair registered
// when the back pops it; steps sustain one transaction per cycle while the queue has
// room and results are taken. A start transaction holds the input through clip and
// order, the restoring slope divider and the queue write; rejects skip the divider.
// Reset clears the line, the queue and the output; width 256, height 240.
// Depends on alsu_pkg, alsu_front, alsu_queue, alsu_back and the macro header.
`include "antialiased_line_stepper_unit_macros.svh"

module antialiased_line_stepper_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [alsu_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [alsu_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] first_x_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] first_y_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] second_x_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] second_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  pixel_valid_o,
  output logic [alsu_pkg::PIX_BITS-1:0]         pixel_x_o,
  output logic [alsu_pkg::PIX_BITS-1:0]         pixel_y_o,
  output logic [alsu_pkg::SHADE_BITS-1:0]       shade_near_o,
  output logic [alsu_pkg::SHADE_BITS-1:0]       shade_far_o,
  output logic                                  far_is_below_o,
  output logic                                  line_done_o
);

  logic [alsu_pkg::CFG_BITS-1:0] width_q, height_q;

  logic              q_push, q_pop;
  alsu_pkg::cmd_t    push_cmd, head_cmd;
  alsu_pkg::q_stat_t q_stat;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= alsu_pkg::WIDTH_RESET;
      height_q <= alsu_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        alsu_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        alsu_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default:              width_q  <= width_q;
      endcase
    end
  end

  // front: accept, classify, divide
  alsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .q_stat_i     (q_stat),
    .push_o       (q_push),
    .push_cmd_o   (push_cmd)
  );

  // command queue
  alsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_cmd_o (head_cmd),
    .stat_o     (q_stat)
  );

  // back: line state and result register
  alsu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_width_i    (width_q),
    .cfg_height_i   (height_q),
    .q_stat_i       (q_stat),
    .head_cmd_i     (head_cmd),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_valid_o  (pixel_valid_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .shade_near_o   (shade_near_o),
    .shade_far_o    (shade_far_o),
    .far_is_below_o (far_is_below_o),
    .line_done_o    (line_done_o)
  );

  // checks on queue usage and result hand-off
  `ALSU_ASSERT(a_no_push_full, !(q_push && q_stat.full), "push into full queue")
  `ALSU_ASSERT(a_no_pop_empty, !(q_pop && q_stat.empty), "pop from empty queue")
  `ALSU_ASSERT(a_ready_space, !(in_ready_o && q_stat.full), "ready with full queue")
  `ALSU_ASSERT_NEXT(a_pop_shows, q_pop, out_valid_o, "popped command gave no result")

endmodule

// ----- rtl/alsu_queue.sv -----
// short command queue between the front and the back of the line stepper
// depends on alsu_pkg for the command type and depth
module alsu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  alsu_pkg::cmd_t   push_cmd_i,
  input  logic             pop_i,
  output alsu_pkg::cmd_t   head_cmd_o,
  output alsu_pkg::q_stat_t stat_o
);

  alsu_pkg::cmd_t                   mem_q [alsu_pkg::QUEUE_DEPTH];
  logic [alsu_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [alsu_pkg::QPTR_BITS:0]     count_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // head and status
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (alsu_pkg::QPTR_BITS + 1)'(alsu_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

// ----- rtl/alsu_front.sv -----
// front of the line stepper: accepts items, clips and orders start items,
// runs the slope division and queues commands; depends on alsu_pkg
module alsu_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [alsu_pkg::CFG_BITS-1:0]         cfg_width_i,
  input  logic [alsu_pkg::CFG_BITS-1:0]         cfg_height_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] first_x_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] first_y_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] second_x_i,
  input  logic signed [alsu_pkg::COORD_BITS-1:0] second_y_i,
  input  alsu_pkg::q_stat_t                     q_stat_i,
  output logic                                  push_o,
  output alsu_pkg::cmd_t                        push_cmd_o
);

  // margin outcode with a one pixel border on every edge
  function automatic logic [alsu_pkg::OC_BITS-1:0] outcode(
    input logic signed [alsu_pkg::CMP_BITS-1:0] x,
    input logic signed [alsu_pkg::CMP_BITS-1:0] y,
    input logic signed [alsu_pkg::CMP_BITS-1:0] w,
    input logic signed [alsu_pkg::CMP_BITS-1:0] h
  );
    logic [alsu_pkg::OC_BITS-1:0] c;
    c = '0;
    if (y < 1) begin
      c = c | alsu_pkg::OC_TOP;
    end else if (y > h - alsu_pkg::CMP_BITS'(2)) begin
      c = c | alsu_pkg::OC_BOTTOM;
    end
    if (x < 1) begin
      c = c | alsu_pkg::OC_LEFT;
    end else if (x > w - alsu_pkg::CMP_BITS'(2)) begin
      c = c | alsu_pkg::OC_RIGHT;
    end
    return c;
  endfunction

  alsu_pkg::fe_state_e state_q, state_d;

  logic signed [alsu_pkg::COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
  alsu_pkg::cmd_kind_e                    kind_q;
  logic                                   major_x_q;
  logic signed [alsu_pkg::COORD_BITS-1:0] pos_q, end_q;
  logic signed [alsu_pkg::ACC_BITS-1:0]   accum_q;
  logic signed [alsu_pkg::SLOPE_BITS-1:0] slope_q;
  logic                                   neg_q;
  logic [alsu_pkg::MAG_BITS-1:0]          amaj_q;
  logic [alsu_pkg::MAG_BITS:0]            rem_q;
  logic [alsu_pkg::QUO_BITS-1:0]          quo_q;
  logic [alsu_pkg::CNT_BITS-1:0]          cnt_q;

  logic                                   start_acc;
  logic                                   div_last;

  // classification of the latched endpoints
  logic signed [alsu_pkg::CMP_BITS-1:0]   w_s, h_s;
  logic signed [alsu_pkg::DIFF_BITS-1:0]  dx, dy;
  logic [alsu_pkg::MAG_BITS-1:0]          adx, ady;
  logic                                   major_x, reject, swap, neg;
  logic signed [alsu_pkg::COORD_BITS-1:0] c_pos, c_end, c_minor;
  logic [alsu_pkg::MAG_BITS-1:0]          c_amin, c_amaj;

  always_comb begin
    w_s = signed'(alsu_pkg::CMP_BITS'(cfg_width_i));
    h_s = signed'(alsu_pkg::CMP_BITS'(cfg_height_i));
    dx  = alsu_pkg::DIFF_BITS'(x2_q) - alsu_pkg::DIFF_BITS'(x1_q);
    dy  = alsu_pkg::DIFF_BITS'(y2_q) - alsu_pkg::DIFF_BITS'(y1_q);
    adx = dx[alsu_pkg::DIFF_BITS-1] ? alsu_pkg::MAG_BITS'(-dx) : alsu_pkg::MAG_BITS'(dx);
    ady = dy[alsu_pkg::DIFF_BITS-1] ? alsu_pkg::MAG_BITS'(-dy) : alsu_pkg::MAG_BITS'(dy);
    reject = ((outcode(alsu_pkg::CMP_BITS'(x1_q), alsu_pkg::CMP_BITS'(y1_q), w_s, h_s) &
               outcode(alsu_pkg::CMP_BITS'(x2_q), alsu_pkg::CMP_BITS'(y2_q), w_s, h_s))
              != '0) || ((dx == '0) && (dy == '0));
    major_x = (ady < adx);
    neg     = dx[alsu_pkg::DIFF_BITS-1] ^ dy[alsu_pkg::DIFF_BITS-1];
    if (major_x) begin
      swap    = (x1_q > x2_q);
      c_pos   = swap ? x2_q : x1_q;
      c_end   = swap ? x1_q : x2_q;
      c_minor = swap ? y2_q : y1_q;
      c_amin  = ady;
      c_amaj  = adx;
    end else begin
      swap    = (y1_q > y2_q);
      c_pos   = swap ? y2_q : y1_q;
      c_end   = swap ? y1_q : y2_q;
      c_minor = swap ? x2_q : x1_q;
      c_amin  = adx;
      c_amaj  = ady;
    end
  end

  // one restoring division step per cycle
  logic                                   ge;
  logic [alsu_pkg::MAG_BITS:0]            rem_sub;
  logic [alsu_pkg::QUO_BITS-1:0]          quo_next;
  logic signed [alsu_pkg::SLOPE_BITS-1:0] slope_next;

  always_comb begin
    ge       = (rem_q >= {1'b0, amaj_q});
    rem_sub  = ge ? (rem_q - {1'b0, amaj_q}) : rem_q;
    quo_next = {quo_q[alsu_pkg::QUO_BITS-2:0], ge};
    slope_next = neg_q ? -signed'(alsu_pkg::SLOPE_BITS'(quo_next))
                       :  signed'(alsu_pkg::SLOPE_BITS'(quo_next));
  end

  assign div_last = (cnt_q == alsu_pkg::CNT_BITS'(alsu_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      alsu_pkg::FE_IDLE: begin
        if (start_acc) begin
          state_d = alsu_pkg::FE_CLASS;
        end
      end
      alsu_pkg::FE_CLASS: begin
        state_d = reject ? alsu_pkg::FE_PUSH : alsu_pkg::FE_DIV;
      end
      alsu_pkg::FE_DIV: begin
        if (div_last) begin
          state_d = alsu_pkg::FE_PUSH;
        end
      end
      alsu_pkg::FE_PUSH: begin
        if (!q_stat_i.full) begin
          state_d = alsu_pkg::FE_IDLE;
        end
      end
      default: state_d = alsu_pkg::FE_IDLE;
    endcase
  end

  // handshake and queue write
  always_comb begin
    in_ready_o = (state_q == alsu_pkg::FE_IDLE) && !q_stat_i.full;
    start_acc  = in_valid_i && in_ready_o && (action_i == alsu_pkg::ACT_START);
    push_o     = (in_valid_i && in_ready_o && (action_i == alsu_pkg::ACT_STEP)) ||
                 ((state_q == alsu_pkg::FE_PUSH) && !q_stat_i.full);
    push_cmd_o = '0;
    push_cmd_o.kind = alsu_pkg::CMD_STEP;
    if (state_q == alsu_pkg::FE_PUSH) begin
      push_cmd_o.kind        = kind_q;
      push_cmd_o.major_is_x  = major_x_q;
      push_cmd_o.major_pos   = pos_q;
      push_cmd_o.major_end   = end_q;
      push_cmd_o.minor_accum = accum_q;
      push_cmd_o.slope       = slope_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alsu_pkg::FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == alsu_pkg::FE_CLASS) begin
        cnt_q <= '0;
      end else if (state_q == alsu_pkg::FE_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // endpoint, line and divider registers
  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      x1_q <= first_x_i;
      y1_q <= first_y_i;
      x2_q <= second_x_i;
      y2_q <= second_y_i;
    end
    if (state_q == alsu_pkg::FE_CLASS) begin
      kind_q    <= reject ? alsu_pkg::CMD_REJECT : alsu_pkg::CMD_LINE;
      major_x_q <= major_x;
      pos_q     <= c_pos;
      end_q     <= c_end;
      accum_q   <= {alsu_pkg::MINOR_BITS'(c_minor), {alsu_pkg::FRAC_BITS{1'b0}}};
      neg_q     <= neg;
      amaj_q    <= c_amaj;
      rem_q     <= {1'b0, c_amin};
      quo_q     <= '0;
      slope_q   <= '0;
    end
    if (state_q == alsu_pkg::FE_DIV) begin
      rem_q <= {rem_sub[alsu_pkg::MAG_BITS-1:0], 1'b0};
      quo_q <= quo_next;
      if (div_last) begin
        slope_q <= slope_next;
      end
    end
  end

endmodule

// ----- rtl/alsu_back.sv -----
// back of the line stepper: holds the active line, steps it and
// registers one result per command; depends on alsu_pkg
module alsu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [alsu_pkg::CFG_BITS-1:0] cfg_width_i,
  input  logic [alsu_pkg::CFG_BITS-1:0] cfg_height_i,
  input  alsu_pkg::q_stat_t             q_stat_i,
  input  alsu_pkg::cmd_t                head_cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pixel_valid_o,
  output logic [alsu_pkg::PIX_BITS-1:0] pixel_x_o,
  output logic [alsu_pkg::PIX_BITS-1:0] pixel_y_o,
  output logic [alsu_pkg::SHADE_BITS-1:0] shade_near_o,
  output logic [alsu_pkg::SHADE_BITS-1:0] shade_far_o,
  output logic                          far_is_below_o,
  output logic                          line_done_o
);

  // line state
  logic                                   active_q, active_d;
  logic                                   major_x_q, major_x_d;
  logic signed [alsu_pkg::COORD_BITS-1:0] pos_q, pos_d;
  logic signed [alsu_pkg::COORD_BITS-1:0] end_q, end_d;
  logic signed [alsu_pkg::ACC_BITS-1:0]   accum_q, accum_d;
  logic signed [alsu_pkg::SLOPE_BITS-1:0] slope_q, slope_d;

  // result register
  logic                                   out_valid_q;
  logic                                   pv_q, pv_d;
  logic [alsu_pkg::PIX_BITS-1:0]          px_q, px_d, py_q, py_d;
  logic [alsu_pkg::SHADE_BITS-1:0]        sn_q, sn_d, sf_q, sf_d;
  logic                                   below_q, below_d;
  logic                                   done_q, done_d;

  // step datapath
  logic signed [alsu_pkg::MINOR_BITS-1:0] mn;
  logic [alsu_pkg::FRAC_BITS-1:0]         frac, frac_inv;
  logic signed [alsu_pkg::CMP_BITS-1:0]   maj_s, mnr_s, lim_maj, lim_min;
  logic signed [alsu_pkg::CMP_BITS-1:0]   px_s, py_s;
  logic signed [alsu_pkg::DIFF_BITS-1:0]  pos_next;
  logic                                   ok;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    mn       = accum_q[alsu_pkg::ACC_BITS-1:alsu_pkg::FRAC_BITS];
    frac     = accum_q[alsu_pkg::FRAC_BITS-1:0];
    frac_inv = ~frac;
    maj_s    = alsu_pkg::CMP_BITS'(pos_q);
    mnr_s    = alsu_pkg::CMP_BITS'(mn);
    lim_maj  = signed'(alsu_pkg::CMP_BITS'(major_x_q ? cfg_width_i : cfg_height_i));
    lim_min  = signed'(alsu_pkg::CMP_BITS'(major_x_q ? cfg_height_i : cfg_width_i))
               - alsu_pkg::CMP_BITS'(1);
    ok       = (maj_s >= 0) && (maj_s < lim_maj) && (mnr_s >= 0) && (mnr_s < lim_min);
    px_s     = major_x_q ? maj_s : mnr_s;
    py_s     = major_x_q ? mnr_s : maj_s;
    pos_next = alsu_pkg::DIFF_BITS'(pos_q) + alsu_pkg::DIFF_BITS'(1);
  end

  // command decode and state update
  always_comb begin
    active_d  = active_q;
    major_x_d = major_x_q;
    pos_d     = pos_q;
    end_d     = end_q;
    accum_d   = accum_q;
    slope_d   = slope_q;
    pv_d      = 1'b0;
    px_d      = '0;
    py_d      = '0;
    sn_d      = '0;
    sf_d      = '0;
    below_d   = 1'b0;
    done_d    = 1'b1;
    unique case (head_cmd_i.kind)
      alsu_pkg::CMD_STEP: begin
        if (active_q) begin
          if (ok) begin
            pv_d    = 1'b1;
            px_d    = px_s[alsu_pkg::PIX_BITS-1:0];
            py_d    = py_s[alsu_pkg::PIX_BITS-1:0];
            sn_d    = frac_inv[alsu_pkg::FRAC_BITS-1 -: alsu_pkg::SHADE_BITS];
            sf_d    = frac[alsu_pkg::FRAC_BITS-1 -: alsu_pkg::SHADE_BITS];
            below_d = major_x_q;
          end
          accum_d  = accum_q + alsu_pkg::ACC_BITS'(slope_q);
          pos_d    = pos_next[alsu_pkg::COORD_BITS-1:0];
          done_d   = (pos_next >= alsu_pkg::DIFF_BITS'(end_q));
          active_d = !done_d;
        end
      end
      alsu_pkg::CMD_REJECT: begin
        active_d = 1'b0;
      end
      alsu_pkg::CMD_LINE: begin
        active_d  = 1'b1;
        major_x_d = head_cmd_i.major_is_x;
        pos_d     = head_cmd_i.major_pos;
        end_d     = head_cmd_i.major_end;
        accum_d   = head_cmd_i.minor_accum;
        slope_d   = head_cmd_i.slope;
        done_d    = 1'b0;
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line and result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_x_q <= 1'b0;
      pos_q     <= '0;
      end_q     <= '0;
      accum_q   <= '0;
      slope_q   <= '0;
    end else if (pop_o) begin
      major_x_q <= major_x_d;
      pos_q     <= pos_d;
      end_q     <= end_d;
      accum_q   <= accum_d;
      slope_q   <= slope_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pv_q    <= pv_d;
      px_q    <= px_d;
      py_q    <= py_d;
      sn_q    <= sn_d;
      sf_q    <= sf_d;
      below_q <= below_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_valid_o  = pv_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign shade_near_o   = sn_q;
  assign shade_far_o    = sf_q;
  assign far_is_below_o = below_q;
  assign line_done_o    = done_q;

endmodule

// ----- tb/tb_antialiased_line_stepper_unit.sv -----
// self-checking testbench for the antialiased line stepper unit
// depends on alsu_pkg and antialiased_line_stepper_unit; predicts every pixel pair in-bench
`timescale 1ns / 100ps

module tb_antialiased_line_stepper_unit;
  import alsu_pkg::*;

  localparam int FRAC_ONE       = 1 << FRAC_BITS;
  localparam int NUM_PHASES     = 7;
  localparam int RAND_PER_PHASE = 186;
  localparam int SETTLE_CYCLES  = 24;
  localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic                         action;
    logic signed [COORD_BITS-1:0] fx;
    logic signed [COORD_BITS-1:0] fy;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
  } line_cmd_t;

  typedef struct {
    logic                  pv;
    logic [PIX_BITS-1:0]   px;
    logic [PIX_BITS-1:0]   py;
    logic [SHADE_BITS-1:0] sn;
    logic [SHADE_BITS-1:0] sf;
    logic                  below;
    logic                  done;
  } pixel_rec_t;

  // dut ports
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]      cfg_index_i = '0;
  logic [CFG_BITS-1:0]          cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic                         action_i    = 1'b0;
  logic signed [COORD_BITS-1:0] first_x_i   = '0;
  logic signed [COORD_BITS-1:0] first_y_i   = '0;
  logic signed [COORD_BITS-1:0] second_x_i  = '0;
  logic signed [COORD_BITS-1:0] second_y_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         pixel_valid_o;
  logic [PIX_BITS-1:0]          pixel_x_o;
  logic [PIX_BITS-1:0]          pixel_y_o;
  logic [SHADE_BITS-1:0]        shade_near_o;
  logic [SHADE_BITS-1:0]        shade_far_o;
  logic                         far_is_below_o;
  logic                         line_done_o;

  // stimulus and expectation stores
  line_cmd_t  line_cmds[$];
  pixel_rec_t pending_pixels[$];
  line_cmd_t  bus_cmd;
  bit         cmd_on_bus = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // statistics
  int unsigned mismatches      = 0;
  int unsigned queued_items    = 0;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_written  = 0;
  int unsigned starts_seen     = 0;
  int unsigned lines_finished  = 0;

  // predictor state
  logic [CFG_BITS-1:0]          scr_w = WIDTH_RESET;
  logic [CFG_BITS-1:0]          scr_h = HEIGHT_RESET;
  logic                         ln_active  = 1'b0;
  logic                         ln_major_x = 1'b0;
  logic signed [COORD_BITS-1:0] ln_pos     = '0;
  logic signed [COORD_BITS-1:0] ln_end     = '0;
  logic signed [ACC_BITS-1:0]   ln_acc     = '0;
  logic signed [SLOPE_BITS-1:0] ln_slope   = '0;

  // screen settings and idle behavior per phase, extremes included
  int unsigned phase_w [NUM_PHASES] = '{256, 3, 1024, 2047, 0, 320, 97};
  int unsigned phase_h [NUM_PHASES] = '{240, 3, 1024, 5, 2047, 200, 61};
  idle_mode_e  phase_mode [NUM_PHASES] =
    '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH, IDLE_SEND};

  antialiased_line_stepper_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .shade_near_o  (shade_near_o),
    .shade_far_o   (shade_far_o),
    .far_is_below_o(far_is_below_o),
    .line_done_o   (line_done_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // screen margin outcode of one endpoint
  function automatic logic [OC_BITS-1:0] clip_code(int x, int y, int w, int h);
    logic [OC_BITS-1:0] c;
    c = '0;
    if (y < 1) c |= OC_TOP;
    else if (y > h - 2) c |= OC_BOTTOM;
    if (x < 1) c |= OC_LEFT;
    else if (x > w - 2) c |= OC_RIGHT;
    return c;
  endfunction

  // expected pixel pair of one accepted transaction, advances the line state
  function automatic pixel_rec_t predict_pixel(line_cmd_t c);
    pixel_rec_t            r;
    int                    x1, y1, x2, y2, dx, dy, adx, ady, mn, px, py, w, h;
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS-1:0]  inv;
    logic                  ok;
    r = '{default: 0};
    w = int'(scr_w);
    h = int'(scr_h);
    if (c.action == ACT_START) begin
      starts_seen++;
      x1 = int'(c.fx);
      y1 = int'(c.fy);
      x2 = int'(c.sx);
      y2 = int'(c.sy);
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      ln_active = 1'b0;
      // trivial reject or zero length
      if ((clip_code(x1, y1, w, h) & clip_code(x2, y2, w, h)) != '0 ||
          (dx == 0 && dy == 0)) begin
        r.done = 1'b1;
        return r;
      end
      if (ady < adx) begin
        ln_major_x = 1'b1;
        if (x1 > x2) begin
          ln_pos = COORD_BITS'(x2);
          ln_end = COORD_BITS'(x1);
          ln_acc = ACC_BITS'(y2 * FRAC_ONE);
        end else begin
          ln_pos = COORD_BITS'(x1);
          ln_end = COORD_BITS'(x2);
          ln_acc = ACC_BITS'(y1 * FRAC_ONE);
        end
        ln_slope = SLOPE_BITS'((dy * FRAC_ONE) / dx);
      end else begin
        ln_major_x = 1'b0;
        if (y1 > y2) begin
          ln_pos = COORD_BITS'(y2);
          ln_end = COORD_BITS'(y1);
          ln_acc = ACC_BITS'(x2 * FRAC_ONE);
        end else begin
          ln_pos = COORD_BITS'(y1);
          ln_end = COORD_BITS'(y2);
          ln_acc = ACC_BITS'(x1 * FRAC_ONE);
        end
        ln_slope = SLOPE_BITS'((dx * FRAC_ONE) / dy);
      end
      ln_active = 1'b1;
      return r;
    end
    // step with no line
    if (!ln_active) begin
      r.done = 1'b1;
      return r;
    end
    mn   = int'(ln_acc >>> FRAC_BITS);
    frac = ln_acc[FRAC_BITS-1:0];
    inv  = ~frac;
    if (ln_major_x) begin
      px = int'(ln_pos);
      py = mn;
      ok = px >= 0 && px < w && py >= 0 && py < h - 1;
    end else begin
      px = mn;
      py = int'(ln_pos);
      ok = py >= 0 && py < h && px >= 0 && px < w - 1;
    end
    if (ok) begin
      r.pv    = 1'b1;
      r.px    = px[PIX_BITS-1:0];
      r.py    = py[PIX_BITS-1:0];
      r.sn    = inv[FRAC_BITS-1 -: SHADE_BITS];
      r.sf    = frac[FRAC_BITS-1 -: SHADE_BITS];
      r.below = ln_major_x;
    end
    ln_acc = ln_acc + ln_slope;
    ln_pos = ln_pos + COORD_BITS'(1);
    // last pixel before the end pixel
    if (ln_pos >= ln_end) begin
      ln_active = 1'b0;
      r.done    = 1'b1;
      lines_finished++;
    end
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  task automatic push_cmd(logic act, int x1, int y1, int x2, int y2);
    line_cmd_t c;
    c.action = act;
    c.fx     = COORD_BITS'(x1);
    c.fy     = COORD_BITS'(y1);
    c.sx     = COORD_BITS'(x2);
    c.sy     = COORD_BITS'(y2);
    line_cmds.push_back(c);
    queued_items++;
  endtask

  task automatic push_step();
    push_cmd(ACT_STEP, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
  endtask

  // one start plus its steps: mostly short lines near the screen, some cut short or overrun
  task automatic queue_line(int w, int h, int budget);
    int x1, y1, x2, y2, len, minor, dx, dy, n, steps, sel, margin;
    sel = $urandom_range(99);
    if (sel < 85) len = $urandom_range(24, 0);
    else if (sel < 98) len = $urandom_range(150, 25);
    else len = $urandom_range(300, 151);
    minor = $urandom_range(len, 0);
    if ($urandom_range(1) != 0) begin
      dx = len;
      dy = minor;
    end else begin
      dx = minor;
      dy = len;
    end
    if ($urandom_range(1) != 0) dx = -dx;
    if ($urandom_range(1) != 0) dy = -dy;
    margin = ($urandom_range(99) < 10) ? 64 : 4;
    x1 = clamp_coord(int'($urandom_range(w + 2 * margin, 0)) - margin);
    y1 = clamp_coord(int'($urandom_range(h + 2 * margin, 0)) - margin);
    x2 = clamp_coord(x1 + dx);
    y2 = clamp_coord(y1 + dy);
    push_cmd(ACT_START, x1, y1, x2, y2);
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    n = dx > dy ? dx : dy;
    sel = $urandom_range(99);
    if (sel < 10) steps = $urandom_range(n, 0);
    else if (sel >= 92) steps = n + $urandom_range(2, 1);
    else steps = n;
    // keep the half phase near its item budget
    if (steps > budget - 1) steps = budget - 1;
    repeat (steps) push_step();
  endtask

  task automatic queue_random(int count);
    int unsigned mark;
    mark = queued_items;
    while (queued_items - mark < count) begin
      // noise: a lone transaction with arbitrary content
      if ($urandom_range(99) < 8) begin
        push_cmd(1'($urandom_range(1)), int'($urandom), int'($urandom), int'($urandom),
                 int'($urandom));
      end else begin
        queue_line(int'(scr_w), int'(scr_h), count - int'(queued_items - mark));
      end
    end
  endtask

  task automatic queue_directed();
    // step with no line active
    push_cmd(ACT_STEP, 0, 0, 0, 0);
    // zero length line
    push_cmd(ACT_START, 100, 100, 100, 100);
    // both ends beyond the top margin
    push_cmd(ACT_START, 10, 0, 50, 0);
    // extreme endpoints on a diagonal, y major, pixel off screen
    push_cmd(ACT_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    push_cmd(ACT_STEP, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    // x major with endpoints given high to low, then a step past the end
    push_cmd(ACT_START, 14, 22, 10, 20);
    repeat (5) push_step();
    // y major with negative slope truncated toward zero
    push_cmd(ACT_START, 50, 10, 47, 15);
    repeat (5) push_step();
    // starts left of the screen, dropped by the next start
    push_cmd(ACT_START, -3, 5, 3, 5);
    repeat (2) push_step();
    push_cmd(ACT_START, 255, 239, -5, 100);
    repeat (3) push_step();
  endtask

  // wait for every queued transaction and its result, then let the block settle
  task automatic drain_pipeline();
    while (line_cmds.size() != 0 || cmd_on_bus || pending_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both screen registers back to back, valid held across the pair
  task automatic program_screen(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    scr_w = w;
    cfg_index_i <= REG_HEIGHT;
    cfg_data_i  <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    scr_h = h;
    cfg_valid_i <= 1'b0;
  endtask

  // input driver
  always @(posedge clk_i) begin : driver
    pixel_rec_t next_pix;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        next_pix = predict_pixel(bus_cmd);
        pending_pixels.push_back(next_pix);
        items_accepted++;
        cmd_on_bus = 1'b0;
      end
      if (!cmd_on_bus) begin
        if (line_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_cmd    = line_cmds.pop_front();
          cmd_on_bus = 1'b1;
          in_valid_i <= 1'b1;
          action_i   <= bus_cmd.action;
          first_x_i  <= bus_cmd.fx;
          first_y_i  <= bus_cmd.fy;
          second_x_i <= bus_cmd.sx;
          second_y_i <= bus_cmd.sy;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin : monitor
    pixel_rec_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_valid", want.pv, pixel_valid_o);
          check_field("pixel_x", want.px, pixel_x_o);
          check_field("pixel_y", want.py, pixel_y_o);
          check_field("shade_near", want.sn, shade_near_o);
          check_field("shade_far", want.sf, shade_far_o);
          check_field("far_is_below", want.below, far_is_below_o);
          check_field("line_done", want.done, line_done_o);
          results_checked++;
          if (want.pv) pixels_written++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // sequence of phases
  initial begin : sequencer
    int ph;
    int half;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) program_screen(CFG_BITS'(phase_w[ph]), CFG_BITS'(phase_h[ph]));
      case (phase_mode[ph])
        IDLE_SEND: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        IDLE_BOTH: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (ph == 0) begin
        queue_directed();
        drain_pipeline();
      end
      // two halves with a full drain between them
      for (half = 0; half < 2; half++) begin
        queue_random(RAND_PER_PHASE / 2);
        drain_pipeline();
      end
    end
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_pixels.size());
      mismatches++;
    end
    $display("ran %0d transactions over %0d screen settings, %0d starts, %0d lines to the end",
             items_accepted, NUM_PHASES, starts_seen, lines_finished);
    $display("checked %0d results, %0d pixel pairs written, %0d mismatches",
             results_checked, pixels_written, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2000000;
    $display("%0t: run did not finish in time", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
